[sv/ufs_pkg.sv]
`default_nettype none

package ufs_pkg;

  localparam int NODES = 64;
  localparam int IW    = 6;
  localparam int SW    = 7;

  localparam logic [IW:0]   NODES_W  = (IW + 1)'(NODES);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  localparam logic [1:0] ACT_MERGE = 2'd0;
  localparam logic [1:0] ACT_FIND  = 2'd1;
  localparam logic [1:0] ACT_LIST  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic          en;
    logic [IW-1:0] addr;
    logic [IW-1:0] data;
  } ufs_pwr_t;

  typedef struct packed {
    logic          en;
    logic [IW-1:0] addr;
    logic [SW-1:0] data;
  } ufs_swr_t;

endpackage

`default_nettype wire

[sv/ufs_req_if.sv]
`default_nettype none

interface ufs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] node_a;
  logic [5:0] node_b;

  modport source (output valid, output action, output node_a, output node_b, input ready);
  modport sink (input valid, input action, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

[sv/ufs_rsp_if.sv]
`default_nettype none

interface ufs_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] node_out;
  logic       merged;
  logic       none_found;
  logic       index_error;
  logic       last;

  modport source (
    output valid, output node_out, output merged, output none_found,
    output index_error, output last, input ready
  );
  modport sink (
    input valid, input node_out, input merged, input none_found,
    input index_error, input last, output ready
  );
endinterface

`default_nettype wire

[sv/ufs_parent_mem.sv]
`default_nettype none

module ufs_parent_mem (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [ufs_pkg::IW-1:0] rd_addr_i,
  input  wire ufs_pkg::ufs_pwr_t     wr_i,
  output logic [ufs_pkg::IW-1:0]     rd_data_o
);

  logic [ufs_pkg::IW-1:0]    mem_q [ufs_pkg::NODES];
  logic [ufs_pkg::NODES-1:0] vld_q;
  logic [ufs_pkg::IW-1:0]    rd_mem_q;
  logic [ufs_pkg::IW-1:0]    rd_addr_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_mem_q  <= mem_q[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // unwritten entries are their own parent
  assign rd_data_o = rd_vld_q ? rd_mem_q : rd_addr_q;

endmodule

`default_nettype wire

[sv/ufs_size_mem.sv]
`default_nettype none

module ufs_size_mem (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [ufs_pkg::IW-1:0] rd_addr_i,
  input  wire ufs_pkg::ufs_swr_t     wr_i,
  output logic [ufs_pkg::SW-1:0]     rd_data_o
);

  logic [ufs_pkg::SW-1:0]    mem_q [ufs_pkg::NODES];
  logic [ufs_pkg::NODES-1:0] vld_q;
  logic [ufs_pkg::SW-1:0]    rd_mem_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_mem_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // unwritten entries hold a set of one
  assign rd_data_o = rd_vld_q ? rd_mem_q : ufs_pkg::SW'(1);

endmodule

`default_nettype wire

[sv/union_find_set_engine_top.sv]
// channel   dir  handshake     payload
// req_i     in   valid/ready   action, node_a, node_b
// rsp_o     out  valid/ready   node_out, merged, none_found, index_error, last
//
// One request at a time; req_i.ready is high only when the sequencer is idle,
// and the accept takes that idle cycle. A find walks to the root, then walks
// the path again, pointing each node on it at the root. Merge is two finds and,
// for distinct roots, links the smaller set's root under the other (on a tie,
// node_a's under node_b's); list adds a find per node. A full output register
// stalls the sequencer only when it must emit. Reset acts at once: per-entry
// valid bits make both stores read as their initial values, no clearing pass.
`default_nettype none

module union_find_set_engine_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ufs_req_if.sink    req_i,
  ufs_rsp_if.source  rsp_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FSTART  = 4'd1;
  localparam logic [3:0] S_WALK    = 4'd2;
  localparam logic [3:0] S_CSTART  = 4'd3;
  localparam logic [3:0] S_COMP    = 4'd4;
  localparam logic [3:0] S_MA_DONE = 4'd5;
  localparam logic [3:0] S_MB_DONE = 4'd6;
  localparam logic [3:0] S_MSZ1    = 4'd7;
  localparam logic [3:0] S_MSZ2    = 4'd8;
  localparam logic [3:0] S_F_DONE  = 4'd9;
  localparam logic [3:0] S_LA_DONE = 4'd10;
  localparam logic [3:0] S_LNODE   = 4'd11;
  localparam logic [3:0] S_LEND    = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [ufs_pkg::IW-1:0] fnode_q, fnode_d, cur_q, cur_d, root_q, root_d;
  logic [ufs_pkg::IW-1:0] ra_q, ra_d, rb_q, rb_d, bnode_q, bnode_d;
  logic [ufs_pkg::IW-1:0] idx_q, idx_d, pend_q, pend_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [ufs_pkg::SW-1:0] sa_q, sa_d;
  logic [ufs_pkg::IW-1:0] res_node_q, res_node_d;
  logic                   res_merged_q, res_merged_d, res_err_q, res_err_d;

  logic [ufs_pkg::IW-1:0] p_raddr, prd, s_raddr;
  logic [ufs_pkg::SW-1:0] srd;
  ufs_pkg::ufs_pwr_t      pwr;
  ufs_pkg::ufs_swr_t      swr;

  logic                   emit, e_merged, e_none, e_err, e_last;
  logic [ufs_pkg::IW-1:0] e_node;
  logic                   rsp_vld_q, slot_free, in_err;

  logic [ufs_pkg::IW-1:0] rsp_node_q;
  logic                   rsp_merged_q, rsp_none_q, rsp_err_q, rsp_last_q;

  ufs_parent_mem u_parent (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (p_raddr),
    .wr_i      (pwr),
    .rd_data_o (prd)
  );

  ufs_size_mem u_size (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (s_raddr),
    .wr_i      (swr),
    .rd_data_o (srd)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign slot_free   = !rsp_vld_q || rsp_o.ready;
  assign in_err = ({1'b0, req_i.node_a} >= ufs_pkg::NODES_W) ||
                  ((req_i.action == ufs_pkg::ACT_MERGE) &&
                   ({1'b0, req_i.node_b} >= ufs_pkg::NODES_W));

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    fnode_d      = fnode_q;
    cur_d        = cur_q;
    root_d       = root_q;
    ra_d         = ra_q;
    rb_d         = rb_q;
    bnode_d      = bnode_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    sa_d         = sa_q;
    res_node_d   = res_node_q;
    res_merged_d = res_merged_q;
    res_err_d    = res_err_q;
    p_raddr      = cur_q;
    s_raddr      = ra_q;
    pwr          = '0;
    swr          = '0;
    emit         = 1'b0;
    e_node       = res_node_q;
    e_merged     = 1'b0;
    e_none       = 1'b0;
    e_err        = 1'b0;
    e_last       = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid && (req_i.action != ufs_pkg::ACT_NONE)) begin
          res_merged_d = 1'b0;
          res_err_d    = 1'b0;
          if (in_err) begin
            res_node_d = '0;
            res_err_d  = 1'b1;
            state_d    = S_EMIT;
          end else begin
            fnode_d = req_i.node_a;
            bnode_d = req_i.node_b;
            state_d = S_FSTART;
            case (req_i.action)
              ufs_pkg::ACT_MERGE: ret_d = S_MA_DONE;
              ufs_pkg::ACT_FIND:  ret_d = S_F_DONE;
              default:            ret_d = S_LA_DONE;
            endcase
          end
        end
      end
      S_FSTART: begin
        p_raddr = fnode_q;
        cur_d   = fnode_q;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (prd == cur_q) begin
          root_d  = cur_q;
          state_d = S_CSTART;
        end else begin
          cur_d   = prd;
          p_raddr = prd;
        end
      end
      S_CSTART: begin
        p_raddr = fnode_q;
        cur_d   = fnode_q;
        state_d = S_COMP;
      end
      S_COMP: begin
        if (cur_q == root_q) begin
          state_d = ret_q;
        end else begin
          pwr.en   = 1'b1;
          pwr.addr = cur_q;
          pwr.data = root_q;
          cur_d    = prd;
          p_raddr  = prd;
        end
      end
      S_MA_DONE: begin
        ra_d    = root_q;
        fnode_d = bnode_q;
        ret_d   = S_MB_DONE;
        state_d = S_FSTART;
      end
      S_MB_DONE: begin
        rb_d = root_q;
        if (root_q == ra_q) begin
          res_node_d = root_q;
          state_d    = S_EMIT;
        end else begin
          s_raddr = ra_q;
          state_d = S_MSZ1;
        end
      end
      S_MSZ1: begin
        sa_d    = srd;
        s_raddr = rb_q;
        state_d = S_MSZ2;
      end
      S_MSZ2: begin
        swr.en       = 1'b1;
        swr.data     = sa_q + srd;
        pwr.en       = 1'b1;
        res_merged_d = 1'b1;
        if (sa_q > srd) begin
          swr.addr   = ra_q;
          pwr.addr   = rb_q;
          pwr.data   = ra_q;
          res_node_d = ra_q;
        end else begin
          swr.addr   = rb_q;
          pwr.addr   = ra_q;
          pwr.data   = rb_q;
          res_node_d = rb_q;
        end
        state_d = S_EMIT;
      end
      S_F_DONE: begin
        res_node_d = root_q;
        state_d    = S_EMIT;
      end
      S_LA_DONE: begin
        ra_d       = root_q;
        idx_d      = '0;
        fnode_d    = '0;
        pend_vld_d = 1'b0;
        ret_d      = S_LNODE;
        state_d    = S_FSTART;
      end
      S_LNODE: begin
        // one node held back so the final one can carry last
        if (!((root_q != ra_q) && pend_vld_q && !slot_free)) begin
          if (root_q != ra_q) begin
            if (pend_vld_q) begin
              emit   = 1'b1;
              e_node = pend_q;
              e_last = 1'b0;
            end
            pend_d     = idx_q;
            pend_vld_d = 1'b1;
          end
          if (idx_q == ufs_pkg::LAST_IDX) begin
            state_d = S_LEND;
          end else begin
            idx_d   = idx_q + 1'b1;
            fnode_d = idx_q + 1'b1;
            state_d = S_FSTART;
          end
        end
      end
      S_LEND: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pend_vld_q) begin
            e_node = pend_q;
          end else begin
            e_node = '0;
            e_none = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_node   = res_node_q;
          e_merged = res_merged_q;
          e_err    = res_err_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      pend_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      pend_vld_q <= pend_vld_d;
      if (emit) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fnode_q      <= fnode_d;
    cur_q        <= cur_d;
    root_q       <= root_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    bnode_q      <= bnode_d;
    idx_q        <= idx_d;
    pend_q       <= pend_d;
    sa_q         <= sa_d;
    res_node_q   <= res_node_d;
    res_merged_q <= res_merged_d;
    res_err_q    <= res_err_d;
    if (emit) begin
      rsp_node_q   <= e_node;
      rsp_merged_q <= e_merged;
      rsp_none_q   <= e_none;
      rsp_err_q    <= e_err;
      rsp_last_q   <= e_last;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.node_out    = rsp_node_q;
  assign rsp_o.merged      = rsp_merged_q;
  assign rsp_o.none_found  = rsp_none_q;
  assign rsp_o.index_error = rsp_err_q;
  assign rsp_o.last        = rsp_last_q;

`ifndef SYNTHESIS
  a_busy_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.action != ufs_pkg::ACT_NONE))
      |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_merge_roots_differ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MSZ2) |-> (ra_q != rb_q))
    else $error("merge linking a root to itself");

  a_comp_not_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_COMP) && pwr.en) |-> (pwr.addr != root_q))
    else $error("path compression overwrote the root");

  a_pend_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LNODE) && pend_vld_q) |-> (pend_q < idx_q))
    else $error("list results out of index order");

  a_emit_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && !rsp_o.ready) |-> !emit)
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire
